FILE: rtl/sges_pkg.sv
// shared types and constants for the shrinking gap exchange sorter
package sges_pkg;

   localparam int MAX_ELEMENTS_DEFAULT = 4096;

   // gap arithmetic
   localparam int WIDE_SHIFT       = 12;
   localparam int FIRST_GAP_SHIFT  = 7;
   localparam int STEP_SHIFT_HI    = 15;
   localparam int STEP_SHIFT_LO    = 14;
   localparam int RESTART_GAP_BASE = 8;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] load_value;
      logic               final_load;
      logic [11:0]        read_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [12:0]        stored_count;
   } rsp_type;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_READ,
      DP_INIT,
      DP_ROUND,
      DP_PAIR_READ,
      DP_EVAL,
      DP_WB,
      DP_WB_ADV,
      DP_GAP_GROW,
      DP_SKIP,
      DP_RETREAT,
      DP_UPPER_DEC,
      DP_RESTART
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      mark;
   } cmd_type;

   typedef struct packed {
      logic few_elements;
      logic lower_lt_upper;
      logic upper_lt_n;
      logic lower_zero;
      logic sorted;
   } status_type;

endpackage

FILE: rtl/shrinking_gap_exchange_sort.sv
// top level of the shrinking gap exchange sorter
// Load words and read words are taken in any cycle that busy is low, one per cycle. A read
// answers on rsp_valid in the cycle after it is taken and cannot be held off; an index
// at or past the stored count reads as zero. A load with final_load set starts the sort and
// raises busy from the next cycle until the set is in order. The sort runs on one store with
// two read ports and one write port: a compare-exchange steps through pair read, evaluate
// and write-back states, and a backward pass adds a retreat state before each one, with
// gap update and skip states after each forward pass. Sets of 0 or 1 elements return to
// idle straight after the init step. There is no clearing pass after reset.
module shrinking_gap_exchange_sort #(
   parameter int MAX_ELEMENTS = sges_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sges_pkg::req_type req_item,
   output logic              rsp_valid,
   output sges_pkg::rsp_type rsp_item,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);
   import sges_pkg::*;

   cmd_type    cmd;
   status_type status;

   sges_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   sges_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_item       (req_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item)
   );

endmodule

FILE: rtl/sges_datapath.sv
// element store, sort pointers, compare-exchange unit and read-out register
module sges_datapath #(
   parameter int MAX_ELEMENTS = sges_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  sges_pkg::cmd_type   cmd,
   input  sges_pkg::req_type   req_item,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   output sges_pkg::status_type status,
   output logic                rsp_valid,
   output sges_pkg::rsp_type   rsp_item
);
   import sges_pkg::*;

   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int RW = CW + 4;

   logic signed [31:0] mem [MAX_ELEMENTS];

   logic [CW-1:0]      count_ff, count_in;
   logic               phase_ff, phase_in;
   logic [CW-1:0]      lower_ff, lower_in;
   logic [CW-1:0]      upper_ff, upper_in;
   logic [CW-1:0]      gap_ff, gap_in;
   logic               sorted_ff, sorted_in;
   logic               desc_ff;
   logic               swap_ff, swap_in;
   logic signed [31:0] rd_a_ff, rd_b_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [12:0]        rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               rd_a_en, rd_b_en;
   logic [AW-1:0]      rd_a_addr;

   logic [CW-1:0]      eff_count;
   logic               room;
   logic               swap;
   logic [CW-1:0]      first_gap, step_base, remain;
   logic [CW:0]        skip_sum;
   logic [RW-1:0]      restart_gap, restart_lim;

   assign eff_count = phase_ff ? '0 : count_ff;
   assign room      = eff_count < CW'(MAX_ELEMENTS);
   assign swap      = desc_ff ? (rd_a_ff < rd_b_ff) : (rd_a_ff > rd_b_ff);
   assign first_gap = CW'((count_ff >> WIDE_SHIFT) + (count_ff >> FIRST_GAP_SHIFT) + 1);
   assign step_base = CW'((count_ff >> STEP_SHIFT_HI) + (count_ff >> STEP_SHIFT_LO) + 1);
   assign remain    = count_ff - lower_ff;
   assign skip_sum  = {1'b0, lower_ff} + {1'b0, gap_ff};
   assign restart_gap = RW'(count_ff >> STEP_SHIFT_HI) + RW'(count_ff >> STEP_SHIFT_LO)
                      + RW'(RESTART_GAP_BASE);
   assign restart_lim = RW'(count_ff) - RW'(1);

   always_comb begin
      count_in     = count_ff;
      phase_in     = phase_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      gap_in       = gap_ff;
      sorted_in    = sorted_ff;
      swap_in      = swap_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = lower_ff[AW-1:0];
      wr_data      = rd_b_ff;
      rd_a_en      = 1'b0;
      rd_b_en      = 1'b0;
      rd_a_addr    = lower_ff[AW-1:0];
      case (cmd.op)
         DP_LOAD: begin
            // a load after a sorted set starts a new set
            phase_in = req_item.final_load;
            count_in = eff_count;
            if (room) begin
               wr_en    = 1'b1;
               wr_addr  = eff_count[AW-1:0];
               wr_data  = req_item.load_value;
               count_in = eff_count + CW'(1);
            end
         end
         DP_READ: begin
            rd_a_en      = 1'b1;
            rd_a_addr    = AW'(req_item.read_index);
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 32'(req_item.read_index) < 32'(count_ff);
            rsp_count_in = 13'(count_ff);
         end
         DP_INIT: begin
            lower_in  = '0;
            upper_in  = first_gap;
            sorted_in = 1'b0;
         end
         DP_ROUND: begin
            gap_in    = step_base;
            sorted_in = 1'b1;
         end
         DP_PAIR_READ: begin
            rd_a_en = 1'b1;
            rd_b_en = 1'b1;
         end
         DP_EVAL: begin
            swap_in = swap;
            if (swap) begin
               wr_en   = 1'b1;
               wr_addr = lower_ff[AW-1:0];
               wr_data = rd_b_ff;
               if (cmd.mark) begin
                  sorted_in = 1'b0;
               end
            end
         end
         DP_WB, DP_WB_ADV: begin
            wr_en   = swap_ff;
            wr_addr = upper_ff[AW-1:0];
            wr_data = rd_a_ff;
            if (cmd.op == DP_WB_ADV) begin
               lower_in = lower_ff + CW'(1);
               upper_in = upper_ff + CW'(1);
            end
         end
         DP_GAP_GROW: begin
            // step grows while a whole block of elements lies beyond
            if ((remain >> WIDE_SHIFT) != '0) begin
               gap_in = gap_ff + CW'(1);
            end
         end
         DP_SKIP: begin
            if (skip_sum >= {1'b0, upper_ff}) begin
               lower_in = upper_ff - CW'(1);
            end else begin
               lower_in = skip_sum[CW-1:0];
            end
         end
         DP_RETREAT: begin
            lower_in = lower_ff - CW'(1);
            upper_in = upper_ff - CW'(1);
         end
         DP_UPPER_DEC: begin
            upper_in = upper_ff - CW'(1);
         end
         DP_RESTART: begin
            lower_in = '0;
            upper_in = (restart_gap > restart_lim) ? CW'(restart_lim) : CW'(restart_gap);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_ff <= mem[upper_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         lower_ff     <= '0;
         upper_ff     <= '0;
         gap_ff       <= '0;
         sorted_ff    <= 1'b0;
         desc_ff      <= 1'b0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         gap_ff       <= gap_in;
         sorted_ff    <= sorted_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            desc_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.few_elements   = count_ff < CW'(2);
   assign status.lower_lt_upper = lower_ff < upper_ff;
   assign status.upper_lt_n     = upper_ff < count_ff;
   assign status.lower_zero     = lower_ff == '0;
   assign status.sorted         = sorted_ff;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item.read_value   = rsp_hit_ff ? rd_a_ff : '0;
   assign rsp_item.stored_count = rsp_count_ff;

endmodule

FILE: rtl/sges_ctrl.sv
// sort sequencer: walks the gap rounds and drives the datapath one step per cycle
module sges_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  sges_pkg::req_type    req_item,
   input  sges_pkg::status_type status,
   output logic                 busy,
   output sges_pkg::cmd_type    cmd
);
   import sges_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_ROUND,
      S_OUTER,
      S_FWD,
      S_FWD_EVAL,
      S_FWD_WB,
      S_GAP,
      S_SKIP,
      S_BWD,
      S_BWD_RD,
      S_BWD_EVAL,
      S_BWD_WB,
      S_ROUND_END
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      cmd.mark = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_item.mode == MODE_READ) begin
                  cmd.op = DP_READ;
               end else begin
                  cmd.op = DP_LOAD;
                  if (req_item.final_load) begin
                     state_in = S_INIT;
                  end
               end
            end
         end
         S_INIT: begin
            cmd.op   = DP_INIT;
            state_in = status.few_elements ? S_IDLE : S_ROUND;
         end
         S_ROUND: begin
            cmd.op   = DP_ROUND;
            state_in = S_OUTER;
         end
         S_OUTER: begin
            state_in = status.lower_lt_upper ? S_FWD : S_ROUND_END;
         end
         S_FWD: begin
            if (status.upper_lt_n) begin
               cmd.op   = DP_PAIR_READ;
               state_in = S_FWD_EVAL;
            end else begin
               state_in = S_GAP;
            end
         end
         S_FWD_EVAL: begin
            cmd.op   = DP_EVAL;
            state_in = S_FWD_WB;
         end
         S_FWD_WB: begin
            cmd.op   = DP_WB_ADV;
            state_in = S_FWD;
         end
         S_GAP: begin
            cmd.op   = DP_GAP_GROW;
            state_in = S_SKIP;
         end
         S_SKIP: begin
            cmd.op   = DP_SKIP;
            state_in = S_BWD;
         end
         S_BWD: begin
            if (status.lower_zero) begin
               cmd.op   = DP_UPPER_DEC;
               state_in = S_OUTER;
            end else begin
               cmd.op   = DP_RETREAT;
               state_in = S_BWD_RD;
            end
         end
         S_BWD_RD: begin
            cmd.op   = DP_PAIR_READ;
            state_in = S_BWD_EVAL;
         end
         S_BWD_EVAL: begin
            // backward passes count toward the done test
            cmd.op   = DP_EVAL;
            cmd.mark = 1'b1;
            state_in = S_BWD_WB;
         end
         S_BWD_WB: begin
            cmd.op   = DP_WB;
            state_in = S_BWD;
         end
         S_ROUND_END: begin
            if (status.sorted) begin
               state_in = S_IDLE;
            end else begin
               cmd.op   = DP_RESTART;
               state_in = S_ROUND;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

FILE: rtl/sges_checker.sv
// port-level checks for the shrinking gap exchange sorter, bound to the top level
module sges_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input sges_pkg::req_type req_item,
   input logic              rsp_valid,
   input sges_pkg::rsp_type rsp_item
);
   import sges_pkg::*;

   logic read_take, final_take;

   assign read_take  = !reset && start && !busy && (req_item.mode == MODE_READ);
   assign final_take = !reset && start && !busy && (req_item.mode == MODE_LOAD)
                     && req_item.final_load;

   // every read word is answered in the next cycle
   read_answered: assert property (@(posedge clock) read_take |=> rsp_valid)
      else $error("read word not answered");

   // no answer without a read word in the previous cycle
   no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(read_take))
      else $error("answer without a read word");

   // a final load always starts a sort
   sort_starts: assert property (@(posedge clock) final_take |=> busy)
      else $error("final load did not start a sort");

   // an empty set can only read as zero
   empty_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.stored_count == '0) |-> rsp_item.read_value == '0)
      else $error("empty set returned data");

   // busy only rises after a start word
   busy_needs_start: assert property (@(posedge clock) disable iff (reset)
      (busy && !$past(busy)) |-> $past(start))
      else $error("sort started without a start word");

endmodule

bind shrinking_gap_exchange_sort sges_checker u_checker (.*);

FILE: tb/tb.sv
// testbench for the shrinking gap exchange sorter: shadow sort, read checks, random load/read sets
`timescale 1ns / 1ps

module tb;
   import sges_pkg::*;

   localparam int MAX_WORDS = MAX_ELEMENTS_DEFAULT;
   localparam int STALL_LIMIT = 2_000_000;
   localparam int PHASE_WORDS = 300;
   localparam logic signed [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'h7fff_ffff;

   // tracks the stored set and the read words still owed by the block
   class sort_shadow;
      logic signed [31:0] words [MAX_WORDS];
      int unsigned        word_count;
      bit                 holds_sorted;
      bit                 descending;
      rsp_type            expected_reads [$];
      int unsigned        errors;

      function new();
         word_count = 0;
         holds_sorted = 0;
         descending = 0;
         errors = 0;
      endfunction

      function bit order_pair(int unsigned a, int unsigned b);
         logic signed [31:0] t;
         bit swap;
         swap = descending ? (words[a] < words[b]) : (words[a] > words[b]);
         if (swap) begin
            t = words[a];
            words[a] = words[b];
            words[b] = t;
         end
         return swap;
      endfunction

      function void gap_exchange_sort();
         int unsigned n, lo, hi, step;
         bit clean;
         n = word_count;
         if (n < 2) return;
         lo = 0;
         hi = (n >> 12) + (n >> 7) + 1;
         clean = 0;
         while (!clean) begin
            step = (n >> 15) + (n >> 14) + 1;
            clean = 1;
            while (lo < hi) begin
               // forward pass, swaps do not count
               while (hi < n) begin
                  void'(order_pair(lo, hi));
                  lo++;
                  hi++;
               end
               if (((n - lo) >> 12) != 0) step++;
               lo += step;
               if (lo >= hi) lo = hi - 1;
               // backward pass, any swap forces another round
               while (lo != 0) begin
                  lo--;
                  hi--;
                  if (order_pair(lo, hi)) clean = 0;
               end
               hi--;
            end
            if (!clean) begin
               lo = 0;
               hi = (n >> 15) + (n >> 14) + 8;
               if (hi > n - 1) hi = n - 1;
            end
         end
      endfunction

      function void note_word(req_type w);
         rsp_type r;
         if (w.mode == MODE_LOAD) begin
            if (holds_sorted) begin
               word_count = 0;
               holds_sorted = 0;
            end
            if (word_count < MAX_WORDS) begin
               words[word_count] = w.load_value;
               word_count++;
            end
            if (w.final_load) begin
               gap_exchange_sort();
               holds_sorted = 1;
            end
         end else begin
            r.read_value = (w.read_index < word_count) ? words[w.read_index] : '0;
            r.stored_count = word_count[12:0];
            expected_reads.push_back(r);
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type exp;
         if (expected_reads.size() == 0) begin
            $display("%0t: unexpected read word, expected none, got value %0d count %0d",
                     $time, got.read_value, got.stored_count);
            errors++;
            return;
         end
         exp = expected_reads.pop_front();
         if (got.read_value !== exp.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, exp.read_value, got.read_value);
            errors++;
         end
         if (got.stored_count !== exp.stored_count) begin
            $display("%0t: stored_count mismatch, expected %0d, got %0d",
                     $time, exp.stored_count, got.stored_count);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_write_en;
   logic    csr_write_data;

   sort_shadow  shadow;
   int unsigned words_sent;
   int unsigned stall_cycles;

   shrinking_gap_exchange_sort uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) shadow.check_word(rsp_item);
   end

   // a hang shows up as a long run of cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[shrinking_gap_exchange_sort] ERROR");
            $finish;
         end
      end
   end

   function automatic req_type make_load(logic signed [31:0] value, logic last);
      req_type w;
      w.mode = MODE_LOAD;
      w.load_value = value;
      w.final_load = last;
      w.read_index = 12'($urandom_range(0, MAX_WORDS - 1));
      return w;
   endfunction

   function automatic req_type make_read(logic [11:0] index);
      req_type w;
      w.mode = MODE_READ;
      w.load_value = $urandom();
      w.final_load = 1'($urandom_range(0, 1));
      w.read_index = index;
      return w;
   endfunction

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 3))
               0: v = WORD_MIN;
               1: v = WORD_MAX;
               2: v = 0;
               default: v = -1;
            endcase
         end
         1: v = $signed($urandom_range(0, 15)) - 8;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   function automatic logic [11:0] pick_index();
      if (shadow.word_count == 0 || $urandom_range(0, 7) == 0)
         return 12'($urandom_range(0, MAX_WORDS - 1));
      return 12'($urandom_range(0, shadow.word_count - 1));
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input req_type w);
      start <= 1'b1;
      req_item <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow.note_word(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic hold_off(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (shadow.expected_reads.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_descending(input bit value);
      drain();
      // a sort started by the last load may still be running
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      shadow.descending = value;
   endtask

   task automatic run_phase(input int pct);
      int unsigned first, size, i, reads;
      bit unfinished;
      first = words_sent;
      while (words_sent - first < PHASE_WORDS) begin
         size = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
         // now and then a set gets no final word and runs on into the next one
         unfinished = ($urandom_range(0, 15) == 0);
         for (i = 0; i < size; i++) begin
            if ($urandom_range(0, 7) == 0) begin
               hold_off(pct);
               send_word(make_read(pick_index()));
            end
            hold_off(pct);
            send_word(make_load(pick_value(), (i == size - 1) && !unfinished));
         end
         reads = $urandom_range(0, 8);
         for (i = 0; i < reads; i++) begin
            hold_off(pct);
            send_word(make_read(pick_index()));
         end
         if ($urandom_range(0, 15) == 0) drain();
      end
   endtask

   initial begin
      int i;
      shadow = new();
      words_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_write_en = 1'b0;
      csr_write_data = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_descending(1'b0);
      // empty store, single element, reads past the count
      send_word(make_read(12'd0));
      send_word(make_load(WORD_MAX, 1'b1));
      send_word(make_read(12'd0));
      send_word(make_read(12'd1));
      send_word(make_read(12'd4095));
      // load after a sorted set starts over, read while loading sees raw order
      send_word(make_load(WORD_MIN, 1'b0));
      send_word(make_read(12'd0));
      send_word(make_load(WORD_MAX, 1'b0));
      send_word(make_load(-1, 1'b0));
      send_word(make_load(0, 1'b0));
      send_word(make_load(1, 1'b1));
      for (i = 0; i <= 5; i++) send_word(make_read(i[11:0]));
      write_descending(1'b1);
      send_word(make_load(1, 1'b0));
      send_word(make_load(WORD_MIN, 1'b0));
      send_word(make_load(WORD_MAX, 1'b0));
      send_word(make_load(-1, 1'b1));
      send_word(make_read(12'd0));
      send_word(make_read(12'd2));
      send_word(make_read(12'd3));

      run_phase(0);
      write_descending(1'b0);
      run_phase(45);
      write_descending(1'b1);
      run_phase(0);
      write_descending(1'b0);
      run_phase(27);

      drain();
      repeat (10) @(posedge clock);
      if (shadow.expected_reads.size() != 0) begin
         $display("%0t: %0d read words never came, expected %0d more, got 0",
                  $time, shadow.expected_reads.size(), shadow.expected_reads.size());
         shadow.errors++;
      end
      if (shadow.errors == 0)
         $display("[shrinking_gap_exchange_sort] OK");
      else
         $display("[shrinking_gap_exchange_sort] ERROR");
      $finish;
   end

endmodule
